[hw/rtl/sha_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types and constants for the front queue, the padding sequencer and
// the compression core.
// ----------------------------------------------------------------------------
package sha_pkg;

  // Default depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned DIGEST_W = 256;

  // Kind of a queued command.
  typedef enum logic {
    OP_BYTE   = 1'b0,
    OP_FINISH = 1'b1
  } op_kind_t;

  // One classified input beat.
  typedef struct packed {
    op_kind_t          kind;
    logic [BYTE_W-1:0] data;
  } op_t;

  // Requests from the padding sequencer to the compression core.
  typedef struct packed {
    logic              push;    // shift one message word into the block window
    logic              last;    // the pushed word completes the block
    logic [WORD_W-1:0] word;
    logic              reinit;  // return the chaining state to the initial values
  } core_req_t;

  // Status of the compression core.
  typedef struct packed {
    logic                    busy;
    logic [7:0][WORD_W-1:0]  hash;
  } core_stat_t;

endpackage

[hw/rtl/sha_front.sv]
// ----------------------------------------------------------------------------
// SHA-256 front queue
// Accepts input beats, classifies them as message bytes or finish commands
// and holds them in a short queue for the padding sequencer.
// ----------------------------------------------------------------------------
module sha_front #(
  parameter int unsigned QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  output logic        q_valid,
  output sha_pkg::op_t q_op,
  input  logic        q_pop
);
  import sha_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push;
  logic             pop;
  op_t              op_in;

  assign in_tready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_op      = q_r[rd_ptr_r];

  always_comb begin
    op_in.kind = in_tuser ? OP_FINISH : OP_BYTE;
    op_in.data = in_tdata;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= op_in;
    end
  end

endmodule

[hw/rtl/sha_core.sv]
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Holds the sixteen-word schedule window, the working variables and the
// chaining state; runs one round per cycle and a final feed-forward add.
// ----------------------------------------------------------------------------
module sha_core (
  input  logic                clk,
  input  logic                rst_n,
  input  sha_pkg::core_req_t  req,
  output sha_pkg::core_stat_t stat
);
  import sha_pkg::*;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] win_r  [16];
  logic [31:0] v_r    [8];
  logic [31:0] hash_r [8];
  logic [5:0]  rnd_r;
  logic        run_r;
  logic        add_r;

  logic [31:0] big1, choose, t1, big0, major, t2, w_new;

  // One SHA-256 round on the working variables and the next schedule word.
  always_comb begin
    big1   = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    choose = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1     = v_r[7] + big1 + choose + ROUND_K[rnd_r] + win_r[0];
    big0   = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    major  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2     = big0 + major;
    w_new  = win_r[0]
           + (rotr(win_r[1], 7) ^ rotr(win_r[1], 18) ^ (win_r[1] >> 3))
           + win_r[9]
           + (rotr(win_r[14], 17) ^ rotr(win_r[14], 19) ^ (win_r[14] >> 10));
  end

  always_comb begin
    stat.busy = run_r || add_r;
    for (int i = 0; i < 8; i++) begin
      stat.hash[i] = hash_r[i];
    end
  end

  // Schedule window and working variables carry no reset.
  always_ff @(posedge clk) begin
    if (req.push) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= req.word;
      if (req.last) begin
        for (int i = 0; i < 8; i++) begin
          v_r[i] <= hash_r[i];
        end
      end
    end else if (run_r) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= w_new;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      add_r <= 1'b0;
      rnd_r <= '0;
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= INIT_HASH[i];
      end
    end else begin
      if (req.push && req.last) begin
        run_r <= 1'b1;
        rnd_r <= '0;
      end else if (run_r) begin
        rnd_r <= rnd_r + 1'b1;
        if (rnd_r == 6'd63) begin
          run_r <= 1'b0;
          add_r <= 1'b1;
        end
      end
      if (add_r) begin
        add_r <= 1'b0;
        for (int i = 0; i < 8; i++) begin
          hash_r[i] <= hash_r[i] + v_r[i];
        end
      end else if (req.reinit) begin
        for (int i = 0; i < 8; i++) begin
          hash_r[i] <= INIT_HASH[i];
        end
      end
    end
  end

endmodule

[hw/rtl/sha_back.sv]
// ----------------------------------------------------------------------------
// SHA-256 padding sequencer
// Takes queued commands, packs bytes into big-endian words for the core,
// pads finished messages and registers the digest for the output channel.
// ----------------------------------------------------------------------------
module sha_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  sha_pkg::op_t        q_op,
  output logic                q_pop,
  output sha_pkg::core_req_t  core_req,
  input  sha_pkg::core_stat_t core_stat,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [255:0]        out_tdata
);
  import sha_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PAD  = 4'b0010,
    ST_LEN  = 4'b0100,
    ST_DONE = 4'b1000
  } back_state_t;

  back_state_t    state_r, state_nxt;
  logic [5:0]     fill_r;
  logic [23:0]    acc_r;
  logic [63:0]    total_r;
  logic [63:0]    len_r;
  logic [2:0]     len_cnt_r;
  logic           out_valid_r;
  logic [255:0]   out_data_r;

  logic           put_en;
  logic [7:0]     put_data;
  logic           put_msg;
  logic           capture;

  always_comb begin
    state_nxt = state_r;
    put_en    = 1'b0;
    put_data  = '0;
    put_msg   = 1'b0;
    q_pop     = 1'b0;
    capture   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && !core_stat.busy) begin
          q_pop  = 1'b1;
          put_en = 1'b1;
          if (q_op.kind == OP_FINISH) begin
            put_data  = 8'h80;
            state_nxt = ST_PAD;
          end else begin
            put_data = q_op.data;
            put_msg  = 1'b1;
          end
        end
      end
      ST_PAD: begin
        if (fill_r == 6'd56) begin
          state_nxt = ST_LEN;
        end else if (!core_stat.busy) begin
          put_en = 1'b1;
        end
      end
      ST_LEN: begin
        if (!core_stat.busy) begin
          put_en   = 1'b1;
          put_data = len_r[63:56];
          if (len_cnt_r == 3'd7) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!core_stat.busy && (!out_valid_r || out_tready)) begin
          capture   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    core_req.push   = put_en && (fill_r[1:0] == 2'b11);
    core_req.last   = put_en && (fill_r == 6'd63);
    core_req.word   = {acc_r, put_data};
    core_req.reinit = capture;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      total_r     <= '0;
      len_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (put_en) begin
        fill_r <= fill_r + 1'b1;
      end
      if (capture) begin
        total_r <= '0;
      end else if (put_msg) begin
        total_r <= total_r + 1'b1;
      end
      if (state_r == ST_LEN && put_en) begin
        len_cnt_r <= len_cnt_r + 1'b1;
      end
      out_valid_r <= (out_valid_r && !out_tready) || capture;
    end
  end

  always_ff @(posedge clk) begin
    if (put_en) begin
      acc_r <= {acc_r[15:0], put_data};
    end
    if (q_pop && q_op.kind == OP_FINISH) begin
      len_r <= {total_r[60:0], 3'b000};
    end else if (state_r == ST_LEN && put_en) begin
      len_r <= {len_r[55:0], 8'h00};
    end
    if (capture) begin
      out_data_r <= {core_stat.hash[6], core_stat.hash[7],
                     core_stat.hash[4], core_stat.hash[5],
                     core_stat.hash[2], core_stat.hash[3],
                     core_stat.hash[0], core_stat.hash[1]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[hw/rtl/sha256_message_hasher_unit.sv]
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Streams message bytes in, returns the 256-bit digest on a finish command.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Beat contents
//  in_      slave      tdata = data_byte[7:0]; tuser = func (1 = finish)
//  out_     master     tdata = digest_w0[63:0], w1[127:64], w2[191:128],
//                      w3[255:192]
//
//  The padding sequencer takes a message byte whenever the core is idle; every
//  64th byte starts a compression (64 rounds and one feed-forward add, run by
//  the single round unit) that keeps the core busy and holds off the bytes.
//  A finish pads up to the next block boundary one byte per cycle while the core
//  is idle, runs one or two compressions and then loads the output register.
//  Reset (rst_n low, synchronous) restores the initial hash values, empties
//  the command queue and clears the byte count.
//  in_tready drops only when the command queue is full; the output register
//  lets the next message be absorbed while a digest waits on out_tready.
//
module sha256_message_hasher_unit #(
  parameter int unsigned QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte[7:0]
  input  logic         in_tuser,   // func
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [255:0] out_tdata   // digest_w0, digest_w1, digest_w2, digest_w3
);
  import sha_pkg::*;

  logic       q_valid;
  op_t        q_op;
  logic       q_pop;
  core_req_t  core_req;
  core_stat_t core_stat;

  // The front classifies each beat and buffers it so that input beats keep
  // flowing until the queue is full while the back pads or waits on a compression.
  sha_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_valid  (q_valid),
    .q_op     (q_op),
    .q_pop    (q_pop)
  );

  // The back packs bytes into words, inserts padding and the bit length,
  // and holds the finished digest in its output register.
  sha_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_pop     (q_pop),
    .core_req  (core_req),
    .core_stat (core_stat),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // The core runs the message schedule and the rounds of each full block.
  sha_core u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (core_req),
    .stat (core_stat)
  );

`ifndef SYNTHESIS
  // A word must never be shifted into the window while rounds are running.
  assert property (@(posedge clk) disable iff (!rst_n)
    core_req.push |-> !core_stat.busy)
    else $error("word pushed into a busy compression core");

  // Completing a block always starts a compression on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (core_req.push && core_req.last) |=> core_stat.busy)
    else $error("full block did not start a compression");

  // The chaining state is only reloaded once the last compression is done.
  assert property (@(posedge clk) disable iff (!rst_n)
    core_req.reinit |-> !core_stat.busy)
    else $error("hash reinitialized during a compression");

  // The back only draws commands that the queue actually holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("command popped from an empty queue");
`endif

endmodule

[tb/sha256_message_hasher_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Streams byte and finish beats into the hasher. A short table of directed
// beats comes first, then random messages whose lengths cluster around the
// block and padding boundaries. Every accepted beat is run through a local
// SHA-256 model, and each digest beat is compared word by word with the
// oldest predicted digest. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module sha256_message_hasher_unit_tb;
  import sha_pkg::*;

  // Cycles without any accepted beat before the run is declared hung.
  localparam int unsigned STALL_LIMIT  = 4000;
  // Length of the deliberate back-pressure stretch on the digest channel.
  localparam int unsigned HOLD_CYCLES  = 500;
  // Quiet cycles after the last digest, to catch a stray extra beat.
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned BEAT_TARGET   = 1700;
  localparam int unsigned DIGEST_TARGET = 20;

  // Digest as it appears on out_tdata: w0 in the lowest 64 bits.
  typedef struct packed {
    logic [63:0] w3;
    logic [63:0] w2;
    logic [63:0] w1;
    logic [63:0] w0;
  } digest_t;

  typedef struct {
    op_kind_t    kind;
    logic [7:0]  data;
    bit          pinned;   // digest below is known in advance
    digest_t     digest;
  } stim_row_t;

  localparam digest_t EMPTY_DIGEST = {64'ha495991b7852b855, 64'h27ae41e4649b934c,
                                      64'h9afbf4c8996fb924, 64'he3b0c44298fc1c14};
  localparam digest_t ABC_DIGEST   = {64'hb410ff61f20015ad, 64'hb00361a396177a9c,
                                      64'h414140de5dae2223, 64'hba7816bf8f01cfea};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Message lengths right at the padding and block edges: 55 bytes still fit
  // the length field in the same block, 56 force an extra block, 64 fill one.
  localparam int unsigned EDGE_LENS [11] = '{55, 56, 57, 63, 64, 65, 119, 120, 121,
                                             127, 128};

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;     // data_byte[7:0]
  logic         in_tuser = 1'b0;      // func
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [255:0] out_tdata;            // digest_w0, digest_w1, digest_w2, digest_w3

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sha256_message_hasher_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // --------------------------------------------------------------------------
  // SHA-256 model state: chaining words, the partly filled block, how many
  // bytes it holds, and the message length in bytes.
  // --------------------------------------------------------------------------
  logic [31:0] chain_words [8];
  logic [7:0]  block_bytes [64];
  int unsigned block_fill;
  logic [63:0] msg_bytes;

  digest_t     digests_due [$];
  int unsigned error_count = 0;
  int unsigned beats_sent = 0;
  int unsigned digests_predicted = 0;
  bit          hold_request = 1'b0;
  bit          sender_burst = 1'b0;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++) chain_words[i] = HASH_IV[i];
    block_fill = 0;
    msg_bytes  = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] sched [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2, ch, maj;
    for (int i = 0; i < 16; i++)
      sched[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                  block_bytes[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
      s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
      sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = chain_words[i];
    for (int i = 0; i < 64; i++) begin
      s1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1  = v[7] + s1 + ch + ROUND_K[i] + sched[i];
      s0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2  = s0 + maj;
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_words[i] += v[i];
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    block_bytes[block_fill] = b;
    block_fill = (block_fill + 1) % 64;
    if (block_fill == 0) compress_block();
  endfunction

  // Applies one accepted beat to the model. Returns 1 with the digest when
  // the beat was a finish.
  function automatic bit hash_beat(input op_kind_t kind, input logic [7:0] data,
                                   output digest_t digest);
    logic [63:0] bit_len;
    digest = '0;
    if (kind == OP_BYTE) begin
      absorb_byte(data);
      msg_bytes += 64'd1;
      return 1'b0;
    end
    // Padding: the 0x80 mark, zeros up to byte 56, then the bit length.
    bit_len = msg_bytes << 3;
    absorb_byte(8'h80);
    while (block_fill != 56) absorb_byte(8'h00);
    for (int i = 0; i < 8; i++) absorb_byte(bit_len[63 - 8*i -: 8]);
    digest.w0 = {chain_words[0], chain_words[1]};
    digest.w1 = {chain_words[2], chain_words[3]};
    digest.w2 = {chain_words[4], chain_words[5]};
    digest.w3 = {chain_words[6], chain_words[7]};
    restart_message();
    return 1'b1;
  endfunction

  // Mostly back-to-back beats, some short gaps and an occasional long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (sender_burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(0, 12);
    if (r < 65) return EDGE_LENS[$urandom_range(0, 10)];
    if (r < 90) return $urandom_range(13, 80);
    return $urandom_range(81, 200);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch %s: got %h, want %h", $time, what, got, want);
    error_count++;
  endtask

  // Offers one beat, waits for the handshake, then runs it through the model.
  // The valid line is touched once per edge, so a back-to-back beat simply
  // keeps it high.
  task automatic send_beat(input op_kind_t kind, input logic [7:0] data,
                           input bit pinned, input digest_t pinned_digest);
    int unsigned gap;
    digest_t     predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    if (hash_beat(kind, data, predicted)) begin
      digests_due.push_back(pinned ? pinned_digest : predicted);
      digests_predicted++;
    end
  endtask

  // Stops offering beats until every predicted digest has come out. Valid goes
  // low before the wait, so the next beat starts on a later edge.
  task automatic drain_digests();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (digests_due.size() != 0);
  endtask

  task automatic send_random_message();
    int unsigned len;
    len = pick_length();
    for (int unsigned i = 0; i < len; i++)
      send_beat(OP_BYTE, 8'($urandom_range(0, 255)), 1'b0, '0);
    // The data byte of a finish beat is ignored, so it carries noise.
    send_beat(OP_FINISH, 8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Digest channel: random ready pattern, plus one long hold-off on request
  // while the sender keeps pushing, so the command queue fills up and the
  // input side stalls.
  // --------------------------------------------------------------------------
  initial begin : digest_sink
    int unsigned r;
    int unsigned span;
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          span = $urandom_range(1, 8);
          out_tready <= 1'b1;
        end else if (r < 65) begin
          span = $urandom_range(50, 200);
          out_tready <= 1'b1;
        end else if (r < 92) begin
          span = $urandom_range(1, 3);
          out_tready <= 1'b0;
        end else begin
          span = $urandom_range(10, 60);
          out_tready <= 1'b0;
        end
        // A pending hold-off cuts the current span short.
        repeat (span) begin
          @(posedge clk);
          if (hold_request) break;
        end
      end
    end
  end

  // Each digest beat is compared with the oldest prediction.
  always @(posedge clk) begin : digest_check
    digest_t got;
    digest_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (digests_due.size() == 0) begin
        report_mismatch("unexpected digest, w0", got.w0, '0);
      end else begin
        want = digests_due.pop_front();
        if (got.w0 !== want.w0) report_mismatch("digest_w0", got.w0, want.w0);
        if (got.w1 !== want.w1) report_mismatch("digest_w1", got.w1, want.w1);
        if (got.w2 !== want.w2) report_mismatch("digest_w2", got.w2, want.w2);
        if (got.w3 !== want.w3) report_mismatch("digest_w3", got.w3, want.w3);
      end
    end
  end

  // Hang detection: the run ends if neither channel moves a beat for too long.
  always @(posedge clk) begin : watchdog
    int unsigned idle_cycles;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("sha256_message_hasher_unit_tb: done, errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed table, then random messages.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t   directed_rows [12];
    int unsigned msg_index;
    directed_rows = '{
      // Finish straight after reset hashes the empty message.
      '{OP_FINISH, 8'h00, 1'b1, EMPTY_DIGEST},
      // A repeated finish starts from the initial values again.
      '{OP_FINISH, 8'h00, 1'b1, EMPTY_DIGEST},
      '{OP_BYTE,   8'h61, 1'b0, '0},
      '{OP_BYTE,   8'h62, 1'b0, '0},
      '{OP_BYTE,   8'h63, 1'b0, '0},
      '{OP_FINISH, 8'h00, 1'b1, ABC_DIGEST},
      '{OP_BYTE,   8'h00, 1'b0, '0},
      '{OP_BYTE,   8'hff, 1'b0, '0},
      '{OP_BYTE,   8'h55, 1'b0, '0},
      '{OP_BYTE,   8'haa, 1'b0, '0},
      '{OP_FINISH, 8'h00, 1'b0, '0},
      // The data byte of a finish must not leak into the digest.
      '{OP_FINISH, 8'hff, 1'b1, EMPTY_DIGEST}
    };
    restart_message();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].kind, directed_rows[i].data,
                directed_rows[i].pinned, directed_rows[i].digest);
    drain_digests();

    msg_index = 0;
    while (beats_sent < BEAT_TARGET || digests_predicted < DIGEST_TARGET) begin
      sender_burst = ($urandom_range(0, 3) == 0);
      // Early on the sink is asked for its long hold-off, and a few messages
      // later the source waits for every digest before going on. Random
      // pauses only start after that, so the hold-off always backs up input.
      if (msg_index == 2) hold_request = 1'b1;
      if (msg_index == 8 || (msg_index > 8 && $urandom_range(0, 99) < 8))
        drain_digests();
      send_random_message();
      msg_index++;
    end

    drain_digests();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("sha256_message_hasher_unit_tb: done, clean");
    end else begin
      $display("sha256_message_hasher_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/sha_pkg.sv
hw/rtl/sha_front.sv
hw/rtl/sha_core.sv
hw/rtl/sha_back.sv
hw/rtl/sha256_message_hasher_unit.sv
tb/sha256_message_hasher_unit_tb.sv
